[rtl/angle_from_xy_assert.svh]
`ifndef ANGLE_FROM_XY_ASSERT_SVH
`define ANGLE_FROM_XY_ASSERT_SVH

`ifndef SYNTHESIS
`define AFX_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("afx assertion failed");
`define AFX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("afx assertion failed");
`else
`define AFX_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define AFX_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[rtl/afx_pkg.sv]
package afx_pkg;

	localparam int ITERATIONS_DEF  = 16;
	localparam int COORD_WIDTH_DEF = 16;
	localparam int MAX_ITERATIONS  = 24;

	// rotor grid: a coordinate carries ROTOR_TOP - COORD_WIDTH fraction bits
	localparam int ROTOR_TOP   = 60;
	localparam int ROTOR_WIDTH = ROTOR_TOP + 2;

	localparam int Z_WIDTH     = 36;
	localparam int ANGLE_WIDTH = 16;
	localparam int ROUND_SHIFT = 19;

	typedef logic [ANGLE_WIDTH-1:0] angle_t;

	localparam logic [63:0] PI_Q60         = 64'h3243F6A8885A308D;
	localparam logic [63:0] PI_Q32         = (PI_Q60 + (64'd1 << 27)) >> 28;
	localparam logic [63:0] QUARTER_PI_Q32 = (PI_Q60 + (64'd1 << 29)) >> 30;
	localparam logic [63:0] TWO_PI_Q32     = PI_Q32 << 1;
	localparam logic [63:0] FULL_CODE      =
		(TWO_PI_Q32 + (64'd1 << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;

	// atan(2^-i) at 2^-32 rad from a truncated 2^-60 series, elaboration only
	function automatic logic [63:0] afx_atan_q32(input int unsigned i);
		logic [63:0] acc;
		logic [63:0] num;
		logic [63:0] den;
		logic [63:0] rem;
		logic [63:0] term;
		int unsigned e;
		if (i == 0) begin
			return QUARTER_PI_Q32;
		end
		acc = '0;
		for (int unsigned k = 0; k < 31; k++) begin
			e = i * (2 * k + 1);
			if (e <= 60) begin
				num  = 64'd1 << (60 - e);
				den  = 64'(2 * k + 1);
				rem  = '0;
				term = '0;
				for (int b = 63; b >= 0; b--) begin
					rem = {rem[62:0], num[b]};
					if (rem >= den) begin
						rem     = rem - den;
						term[b] = 1'b1;
					end
				end
				if (k[0]) begin
					acc = acc - term;
				end else begin
					acc = acc + term;
				end
			end
		end
		return (acc + (64'd1 << 27)) >> 28;
	endfunction

endpackage

[rtl/afx_point_if.sv]
interface afx_point_if
	import afx_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) ();
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] x_coord;
	logic signed [COORD_WIDTH-1:0] y_coord;

	modport source (output valid, output x_coord, output y_coord, input ready);
	modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

[rtl/afx_angle_if.sv]
interface afx_angle_if
	import afx_pkg::*;
();
	logic   valid;
	logic   ready;
	angle_t angle;
	logic   origin_flag;

	modport source (output valid, output angle, output origin_flag, input ready);
	modport sink   (input valid, input angle, input origin_flag, output ready);
endinterface

[rtl/afx_prep.sv]
module afx_prep
	import afx_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int W           = ROTOR_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COORD_WIDTH-1:0] x_coord,
	input  logic signed [COORD_WIDTH-1:0] y_coord,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [W-1:0]           x_out,
	output logic signed [W-1:0]           y_out,
	output logic signed [Z_WIDTH-1:0]     z_out,
	output logic                          origin_out
);
	logic                     valid_s1;
	logic signed [W-1:0]      x_s1;
	logic signed [W-1:0]      y_s1;
	logic signed [Z_WIDTH-1:0] z_s1;
	logic                     origin_s1;
	logic signed [W-1:0]      x_sc;
	logic signed [W-1:0]      y_sc;
	logic                     neg;

	// scale onto the rotor grid, left half plane turned by pi
	assign x_sc     = {{2{x_coord[COORD_WIDTH-1]}}, x_coord, {(ROTOR_TOP - COORD_WIDTH){1'b0}}};
	assign y_sc     = {{2{y_coord[COORD_WIDTH-1]}}, y_coord, {(ROTOR_TOP - COORD_WIDTH){1'b0}}};
	assign neg      = x_coord[COORD_WIDTH-1];
	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			x_s1      <= neg ? -x_sc : x_sc;
			y_s1      <= neg ? -y_sc : y_sc;
			z_s1      <= neg ? Z_WIDTH'(PI_Q32) : '0;
			origin_s1 <= (x_coord == '0) && (y_coord == '0);
		end
	end

	assign out_valid  = valid_s1;
	assign x_out      = x_s1;
	assign y_out      = y_s1;
	assign z_out      = z_s1;
	assign origin_out = origin_s1;
endmodule

[rtl/afx_rotor.sv]
module afx_rotor
	import afx_pkg::*;
#(
	parameter int W    = ROTOR_WIDTH,
	parameter int STEP = 0
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [W-1:0]       x_in,
	input  logic signed [W-1:0]       y_in,
	input  logic signed [Z_WIDTH-1:0] z_in,
	input  logic                      origin_in,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [W-1:0]       x_out,
	output logic signed [W-1:0]       y_out,
	output logic signed [Z_WIDTH-1:0] z_out,
	output logic                      origin_out
);
	localparam logic signed [Z_WIDTH-1:0] ATAN_STEP = Z_WIDTH'(afx_atan_q32(STEP));

	logic                      valid_s1;
	logic signed [W-1:0]       x_s1;
	logic signed [W-1:0]       y_s1;
	logic signed [Z_WIDTH-1:0] z_s1;
	logic                      origin_s1;
	logic signed [W-1:0]       xs;
	logic signed [W-1:0]       ys;
	logic                      y_neg;

	assign xs       = x_in >>> STEP;
	assign ys       = y_in >>> STEP;
	assign y_neg    = y_in[W-1];
	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			if (y_neg) begin
				x_s1 <= x_in - ys;
				y_s1 <= y_in + xs;
				z_s1 <= z_in - ATAN_STEP;
			end else begin
				x_s1 <= x_in + ys;
				y_s1 <= y_in - xs;
				z_s1 <= z_in + ATAN_STEP;
			end
			origin_s1 <= origin_in;
		end
	end

	assign out_valid  = valid_s1;
	assign x_out      = x_s1;
	assign y_out      = y_s1;
	assign z_out      = z_s1;
	assign origin_out = origin_s1;
endmodule

[rtl/afx_finish.sv]
module afx_finish
	import afx_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [Z_WIDTH-1:0] z_in,
	input  logic                      origin_in,
	output logic                      out_valid,
	input  logic                      out_ready,
	output angle_t                    angle,
	output logic                      origin_flag
);
	localparam int CODE_WIDTH = Z_WIDTH - ROUND_SHIFT;
	localparam logic [CODE_WIDTH-1:0] FULL_CODE_C = CODE_WIDTH'(FULL_CODE);

	logic                  valid_s1;
	logic [Z_WIDTH-1:0]    tot_s1;
	logic                  origin_s1;
	logic                  valid_s2;
	angle_t                angle_s2;
	logic                  origin_s2;
	logic                  rdy_s2;
	logic [Z_WIDTH-1:0]    rnd;
	logic [CODE_WIDTH-1:0] code;
	angle_t                angle_d;

	assign rdy_s2   = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || rdy_s2;

	// wrap into one turn
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			tot_s1    <= z_in[Z_WIDTH-1] ? Z_WIDTH'(z_in) + Z_WIDTH'(TWO_PI_Q32)
			                             : Z_WIDTH'(z_in);
			origin_s1 <= origin_in;
		end
	end

	// round half up and saturate below a full turn; the origin gives angle zero
	assign rnd  = tot_s1 + (Z_WIDTH'(1) << (ROUND_SHIFT - 1));
	assign code = rnd[Z_WIDTH-1:ROUND_SHIFT];

	always_comb begin
		priority if (origin_s1) begin
			angle_d = '0;
		end else if (code >= FULL_CODE_C) begin
			angle_d = ANGLE_WIDTH'(FULL_CODE_C - CODE_WIDTH'(1));
		end else begin
			angle_d = code[ANGLE_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (rdy_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && valid_s1) begin
			angle_s2  <= angle_d;
			origin_s2 <= origin_s1;
		end
	end

	assign out_valid   = valid_s2;
	assign angle       = angle_s2;
	assign origin_flag = origin_s2;
endmodule

[rtl/angle_from_xy.sv]
// angle_from_xy: polar angle of a signed point, full circle
//
// point  : sink channel, beats carry x_coord and y_coord (two's complement)
// result : source channel, beats carry angle (unsigned Q3.13 radians, below
//          two pi) and origin_flag (set with angle zero when x = y = 0)
//
// a pipelined vectoring rotor, one micro-rotation per register stage: one
// input register, ITERATIONS rotation stages, a wrap stage and an output
// register; throughput is one beat per clock while result.ready stays
// high, bounded by the one-rotation-per-stage adder path
//
// every stage has its own valid bit and local ready; a stalled result
// holds its beat while empty stages upstream keep filling, and point.ready
// drops only once every stage holds a beat
// arst_n empties the pipeline at once; no beat is delivered until new
// points arrive
module angle_from_xy
	import afx_pkg::*;
#(
	parameter int ITERATIONS  = ITERATIONS_DEF,
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	afx_point_if.sink          point,
	afx_angle_if.source        result
);
	localparam int W = ROTOR_WIDTH;

	logic signed [W-1:0]       x_p      [ITERATIONS+1];
	logic signed [W-1:0]       y_p      [ITERATIONS+1];
	logic signed [Z_WIDTH-1:0] z_p      [ITERATIONS+1];
	logic                      origin_p [ITERATIONS+1];
	logic                      valid_p  [ITERATIONS+1];
	logic                      ready_p  [ITERATIONS+1];

	afx_prep #(
		.COORD_WIDTH (COORD_WIDTH),
		.W           (W)
	) u_prep (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (point.valid),
		.in_ready   (point.ready),
		.x_coord    (point.x_coord),
		.y_coord    (point.y_coord),
		.out_valid  (valid_p[0]),
		.out_ready  (ready_p[0]),
		.x_out      (x_p[0]),
		.y_out      (y_p[0]),
		.z_out      (z_p[0]),
		.origin_out (origin_p[0])
	);

	for (genvar g = 0; g < ITERATIONS; g++) begin : g_rotor
		afx_rotor #(
			.W    (W),
			.STEP (g)
		) u_rotor (
			.clk        (clk),
			.arst_n     (arst_n),
			.in_valid   (valid_p[g]),
			.in_ready   (ready_p[g]),
			.x_in       (x_p[g]),
			.y_in       (y_p[g]),
			.z_in       (z_p[g]),
			.origin_in  (origin_p[g]),
			.out_valid  (valid_p[g+1]),
			.out_ready  (ready_p[g+1]),
			.x_out      (x_p[g+1]),
			.y_out      (y_p[g+1]),
			.z_out      (z_p[g+1]),
			.origin_out (origin_p[g+1])
		);
	end

	afx_finish u_finish (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (valid_p[ITERATIONS]),
		.in_ready    (ready_p[ITERATIONS]),
		.z_in        (z_p[ITERATIONS]),
		.origin_in   (origin_p[ITERATIONS]),
		.out_valid   (result.valid),
		.out_ready   (result.ready),
		.angle       (result.angle),
		.origin_flag (result.origin_flag)
	);

`include "angle_from_xy_assert.svh"

	`AFX_ASSERT_IMPLIES(a_origin_zero, clk, arst_n,
		result.valid && result.origin_flag, result.angle == '0)
	`AFX_ASSERT_IMPLIES(a_below_turn, clk, arst_n,
		result.valid, result.angle < ANGLE_WIDTH'(FULL_CODE))
	`AFX_ASSERT_IMPLIES(a_stall_source, clk, arst_n,
		!point.ready, result.valid && !result.ready)
	`AFX_ASSERT_NEXT(a_origin_latency, clk, arst_n,
		ready_p[0] && valid_p[0] && origin_p[0] && ready_p[1], origin_p[1])
endmodule

[test/angle_from_xy_test.sv]
module angle_from_xy_test;
	import afx_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ROTATIONS   = ITERATIONS_DEF;
	localparam int COORD_W     = COORD_WIDTH_DEF;
	localparam int LATENCY     = ROTATIONS + 3;
	localparam int PRE_SHIFT   = 60 - COORD_W;
	localparam int CYCLE_LIMIT = 300000;

	localparam logic [63:0] PI_AT_60 = 64'h3243F6A8885A308D;
	localparam longint PI_AT_32      = longint'((PI_AT_60 + (64'd1 << 27)) >> 28);
	localparam longint EIGHTH_TURN   = longint'((PI_AT_60 + (64'd1 << 29)) >> 30);
	localparam longint TWO_PI_AT_32  = 2 * PI_AT_32;
	localparam logic [63:0] FULL_TURN_CODE =
		(64'(TWO_PI_AT_32) + (64'd1 << 18)) >> 19;

	typedef struct packed {
		angle_t angle;
		logic   origin_flag;
	} angle_beat_t;

	logic clk;
	logic arst_n;

	afx_point_if #(.COORD_WIDTH(COORD_W)) point_ch ();
	afx_angle_if result_ch ();

	angle_from_xy #(
		.ITERATIONS (ROTATIONS),
		.COORD_WIDTH(COORD_W)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.point (point_ch),
		.result(result_ch)
	);

	longint      atan_q32 [0:ROTATIONS-1];
	angle_beat_t expected_angles [$];
	int          send_idle_pct;
	int          recv_idle_pct;
	int          stall_cycles_left;
	int          mismatches;
	int          points_sent;
	int          results_checked;
	int          origin_results;
	int          cycles;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin : atan_table_init
		logic [63:0] acc;
		logic [63:0] term;
		int          e;
		for (int i = 0; i < ROTATIONS; i++) begin
			if (i == 0) begin
				atan_q32[i] = EIGHTH_TURN;
			end else begin
				acc = '0;
				for (int k = 0; i * (2 * k + 1) <= 60; k++) begin
					e    = i * (2 * k + 1);
					term = (64'd1 << (60 - e)) / 64'(2 * k + 1);
					if (k % 2 == 1) begin
						acc = acc - term;
					end else begin
						acc = acc + term;
					end
				end
				atan_q32[i] = longint'((acc + (64'd1 << 27)) >> 28);
			end
		end
	end

	function automatic angle_beat_t predict_angle(input logic signed [COORD_W-1:0] xc,
			input logic signed [COORD_W-1:0] yc);
		angle_beat_t beat;
		longint      x;
		longint      y;
		longint      z;
		longint      xs;
		longint      ys;
		longint      total;
		logic [63:0] code;
		beat = '0;
		if (xc == 0 && yc == 0) begin
			beat.origin_flag = 1'b1;
			return beat;
		end
		x = longint'(xc) * (longint'(1) <<< PRE_SHIFT);
		y = longint'(yc) * (longint'(1) <<< PRE_SHIFT);
		total = 0;
		if (x < 0) begin
			x     = -x;
			y     = -y;
			total = PI_AT_32;
		end
		z = 0;
		for (int i = 0; i < ROTATIONS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y < 0) begin
				x = x - ys;
				y = y + xs;
				z = z - atan_q32[i];
			end else begin
				x = x + ys;
				y = y - xs;
				z = z + atan_q32[i];
			end
		end
		total = total + z;
		if (total < 0) begin
			total = total + TWO_PI_AT_32;
		end
		code = (64'(total) + (64'd1 << 18)) >> 19;
		if (code >= FULL_TURN_CODE) begin
			code = FULL_TURN_CODE - 1;
		end
		beat.angle = code[ANGLE_WIDTH-1:0];
		return beat;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		if (mismatches < 50) begin
			$display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
		end
		mismatches++;
	endtask

	// receiver side: random ready, or a counted hold-off
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_cycles_left > 0) begin
				result_ch.ready <= 1'b0;
				stall_cycles_left--;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin : result_check
		angle_beat_t want;
		if (arst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			if (expected_angles.size() == 0) begin
				report_mismatch("unexpected beat, angle", result_ch.angle, -1);
			end else begin
				want = expected_angles.pop_front();
				results_checked++;
				if (want.origin_flag) begin
					origin_results++;
				end
				if (result_ch.angle !== want.angle) begin
					report_mismatch("angle", result_ch.angle, want.angle);
				end
				if (result_ch.origin_flag !== want.origin_flag) begin
					report_mismatch("origin_flag", result_ch.origin_flag, want.origin_flag);
				end
			end
		end
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles, %0d results pending", cycles,
			expected_angles.size());
		$display("CHECK FAILED");
		$finish;
	end

	task automatic send_point(input logic signed [COORD_W-1:0] xc,
			input logic signed [COORD_W-1:0] yc);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			point_ch.valid <= 1'b0;
			@(negedge clk);
		end
		point_ch.valid   <= 1'b1;
		point_ch.x_coord <= xc;
		point_ch.y_coord <= yc;
		do begin
			@(posedge clk);
		end while (point_ch.ready !== 1'b1);
		expected_angles.push_back(predict_angle(xc, yc));
		points_sent++;
	endtask

	task automatic wait_results_drained();
		@(negedge clk);
		point_ch.valid <= 1'b0;
		while (expected_angles.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic test_directed_points();
		send_idle_pct = 25;
		recv_idle_pct = 74;
		// origin
		send_point(16'sd0, 16'sd0);
		// axes and negative axis
		send_point(16'sd32767, 16'sd0);
		send_point(-16'sd32768, 16'sd0);
		send_point(-16'sd1, 16'sd0);
		send_point(16'sd1, 16'sd0);
		send_point(16'sd0, 16'sd32767);
		send_point(16'sd0, -16'sd32768);
		send_point(16'sd0, 16'sd1);
		send_point(16'sd0, -16'sd1);
		// corners and points beside the negative x axis
		send_point(16'sd32767, 16'sd32767);
		send_point(-16'sd32768, -16'sd32768);
		send_point(-16'sd32768, 16'sd32767);
		send_point(16'sd32767, -16'sd32768);
		send_point(-16'sd32768, -16'sd1);
		send_point(-16'sd32768, 16'sd1);
		// just below a full turn, saturation, then diagonals and the origin
		send_point(16'sd32767, -16'sd1);
		send_point(16'sd32767, -16'sd2);
		send_point(16'sd16384, -16'sd1);
		send_point(16'sd1, -16'sd1);
		send_point(-16'sd1, 16'sd1);
		send_point(-16'sd1, -16'sd1);
		send_point(16'sd0, 16'sd0);
		wait_results_drained();
	endtask

	task automatic test_random_points(input int sender_pct, input int receiver_pct,
			input int count);
		int xi;
		int yi;
		int pick [5] = '{-32768, -1, 0, 1, 32767};
		send_idle_pct = sender_pct;
		recv_idle_pct = receiver_pct;
		for (int n = 0; n < count; n++) begin
			case ($urandom_range(9))
				5: begin
					xi = int'($urandom_range(6)) - 3;
					yi = int'($urandom_range(6)) - 3;
				end
				6: begin
					xi = $urandom_range(1) ? 0 : int'($urandom);
					yi = (xi == 0) ? int'($urandom) : 0;
				end
				7: begin
					xi = $urandom_range(32767, 1000);
					yi = -int'($urandom_range(8, 1));
				end
				8: begin
					xi = -int'($urandom_range(32768, 1));
					yi = int'($urandom_range(4)) - 2;
				end
				9: begin
					xi = pick[$urandom_range(4)];
					yi = pick[$urandom_range(4)];
				end
				default: begin
					xi = $urandom;
					yi = $urandom;
				end
			endcase
			send_point(COORD_W'(xi), COORD_W'(yi));
		end
		wait_results_drained();
	endtask

	// result side held off while points keep coming, so the pipe fills
	task automatic test_result_stall();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		@(negedge clk);
		stall_cycles_left = 400;
		for (int n = 0; n < 80; n++) begin
			send_point(COORD_W'($urandom), COORD_W'($urandom));
		end
		wait_results_drained();
	endtask

	initial begin
		arst_n            = 1'b0;
		point_ch.valid    = 1'b0;
		point_ch.x_coord  = '0;
		point_ch.y_coord  = '0;
		send_idle_pct     = 0;
		recv_idle_pct     = 0;
		stall_cycles_left = 0;
		mismatches        = 0;
		points_sent       = 0;
		results_checked   = 0;
		origin_results    = 0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		test_directed_points();
		test_random_points(25, 74, 370);
		test_random_points(74, 25, 370);
		test_result_stall();
		test_random_points(0, 0, 410);

		wait_results_drained();
		repeat (2 * LATENCY) @(posedge clk);
		if (expected_angles.size() != 0) begin
			report_mismatch("results left over", expected_angles.size(), 0);
		end
		$display("%0d points sent, %0d angles checked (%0d at the origin)", points_sent,
			results_checked, origin_results);
		$display("axes, corners, near-full-turn saturation, three idle mixes, long result stall");
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

[files.f]
+incdir+rtl
rtl/afx_pkg.sv
rtl/afx_point_if.sv
rtl/afx_angle_if.sv
rtl/afx_prep.sv
rtl/afx_rotor.sv
rtl/afx_finish.sv
rtl/angle_from_xy.sv
test/angle_from_xy_test.sv
